// File: design/spectrum_band_peak_meter_assert.svh
// Assertion macros used by the spectrum band peak meter top module.
`ifndef SPECTRUM_BAND_PEAK_METER_ASSERT_SVH
`define SPECTRUM_BAND_PEAK_METER_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define SPBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define SPBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/spbm_pkg.sv
// Types, tables and helper functions for the spectrum band peak meter.
package spbm_pkg;

    localparam int EdgeCount = 17;
    localparam int LevelCount = 16;
    localparam logic [7:0] GlyphBlank = 8'h20;

    // Logarithmic band edges (first bin of each band, then the top bound).
    localparam logic [12:0] BAND_EDGE [0:EdgeCount-1] = '{
        13'd1, 13'd2, 13'd3, 13'd4, 13'd7, 13'd11, 13'd18, 13'd29, 13'd47,
        13'd76, 13'd123, 13'd199, 13'd322, 13'd521, 13'd842, 13'd1363, 13'd2205
    };

    // ceil(exp(0.8*k) * 2^16) for k = 1..16, Q32.16.
    localparam logic [47:0] LEVEL_THRESH [0:LevelCount-1] = '{
        48'd145854, 48'd324602, 48'd722415, 48'd1607764,
        48'd3578145, 48'd7963307, 48'd17722666, 48'd39442517,
        48'd87780935, 48'd195360063, 48'd434781816, 48'd967624725,
        48'd2153488429, 48'd4792676636, 48'd10666298011, 48'd23738282778
    };

    typedef struct packed {
        logic [11:0]        bin_index;
        logic signed [23:0] bin_real;
        logic signed [23:0] bin_imag;
    } t_bin_beat;

    typedef struct packed {
        logic [3:0] band_number;
        logic [4:0] bar_level;
        logic [7:0] upper_glyph;
        logic [7:0] lower_glyph;
        logic       frame_done;
    } t_band_beat;

    // Squared parts of one bin with its band position.
    typedef struct packed {
        logic [3:0]  band;
        logic        first;
        logic        last;
        logic [47:0] sq_re;
        logic [47:0] sq_im;
    } t_sq_beat;

    // Final band peak waiting for level conversion.
    typedef struct packed {
        logic [3:0]  band;
        logic [47:0] peak;
    } t_peak_beat;

    function automatic logic [7:0] glyph_upper(input logic [4:0] lvl);
        logic [7:0] g;
        if (lvl >= 5'd9) begin
            g = {3'b000, lvl - 5'd9};
        end else begin
            g = GlyphBlank;
        end
        return g;
    endfunction

    function automatic logic [7:0] glyph_lower(input logic [4:0] lvl);
        logic [7:0] g;
        if (lvl == 5'd0) begin
            g = GlyphBlank;
        end else if (lvl >= 5'd8) begin
            g = 8'd7;
        end else begin
            g = {3'b000, lvl - 5'd1};
        end
        return g;
    endfunction

endpackage

// File: design/spbm_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface spbm_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: design/spbm_front.sv
// Input register, band lookup, magnitude of parts and squaring.
module spbm_front import spbm_pkg::*; #(
    parameter int NUM_BANDS = 16,
    parameter int TOP_BIN = 2205
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_bin_beat i_beat,
    output logic      o_ready,
    output logic      o_valid,
    output t_sq_beat  o_beat,
    input  logic      i_ready
);

    localparam logic [12:0] TopBin = 13'(TOP_BIN);
    localparam logic [3:0] LastBand = 4'(NUM_BANDS - 1);

    logic        r_v1;
    t_bin_beat   r_beat1;
    logic        r_v2;
    logic [3:0]  r_band2;
    logic        r_first2;
    logic        r_last2;
    logic [23:0] r_abs_re2;
    logic [23:0] r_abs_im2;

    logic        w_rdy1;
    logic        w_rdy2;
    logic        w_in_range;
    logic [12:0] w_in_bin;
    logic [12:0] w_bin;
    logic [3:0]  w_band;
    logic [12:0] w_upper;
    logic        w_first;
    logic        w_last;
    logic [23:0] w_abs_re;
    logic [23:0] w_abs_im;

    assign w_rdy2 = !r_v2 || i_ready;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Drop beats whose bin lies outside the spectrum
    assign w_in_bin = {1'b0, i_beat.bin_index};
    assign w_in_range = (w_in_bin >= BAND_EDGE[0]) && (w_in_bin < TopBin);

    // Hold the accepted bin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid && w_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_beat1 <= i_beat;
        end
    end

    // Find the band and whether this bin opens or closes it
    assign w_bin = {1'b0, r_beat1.bin_index};

    always_comb begin
        w_band = 4'd0;
        for (int i = 1; i < NUM_BANDS; i++) begin
            if (w_bin >= BAND_EDGE[i]) begin
                w_band = 4'(i);
            end
        end
        if (w_band == LastBand) begin
            w_upper = TopBin;
        end else begin
            w_upper = BAND_EDGE[{1'b0, w_band} + 5'd1];
        end
        if (w_upper > TopBin) begin
            w_upper = TopBin;
        end
    end

    assign w_first = (w_bin == BAND_EDGE[{1'b0, w_band}]);
    assign w_last = ((w_bin + 13'd1) == w_upper);

    // Take magnitudes of the two's complement parts
    assign w_abs_re = r_beat1.bin_real[23] ? (~r_beat1.bin_real + 24'd1) : r_beat1.bin_real;
    assign w_abs_im = r_beat1.bin_imag[23] ? (~r_beat1.bin_imag + 24'd1) : r_beat1.bin_imag;

    // Advance to the squaring stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_band2   <= w_band;
            r_first2  <= w_first;
            r_last2   <= w_last;
            r_abs_re2 <= w_abs_re;
            r_abs_im2 <= w_abs_im;
        end
    end

    // Square each part; the sum is formed after the product register
    assign o_valid = r_v2;
    assign o_beat.band  = r_band2;
    assign o_beat.first = r_first2;
    assign o_beat.last  = r_last2;
    assign o_beat.sq_re = 48'(r_abs_re2) * 48'(r_abs_re2);
    assign o_beat.sq_im = 48'(r_abs_im2) * 48'(r_abs_im2);

endmodule

// File: design/spbm_peak.sv
// Squared magnitude sum and running band maximum.
module spbm_peak import spbm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_sq_beat   i_beat,
    output logic       o_ready,
    output logic       o_valid,
    output t_peak_beat o_beat,
    input  logic       i_ready
);

    logic        r_v3;
    t_sq_beat    r_b3;
    logic [47:0] r_peak;
    logic [3:0]  r_cur_band;
    logic        r_v4;
    t_peak_beat  r_b4;

    logic        w_rdy4;
    logic        w_pass3;
    logic        w_fire3;
    logic        w_rdy3;
    logic [47:0] w_sq;
    logic [47:0] w_base;
    logic [47:0] w_new;

    // A beat that closes no band leaves without the report stage
    assign w_rdy4  = !r_v4 || i_ready;
    assign w_pass3 = !r_b3.last || w_rdy4;
    assign w_fire3 = r_v3 && w_pass3;
    assign w_rdy3  = !r_v3 || w_pass3;
    assign o_ready = w_rdy3;

    // Hold the squared parts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && i_valid) begin
            r_b3 <= i_beat;
        end
    end

    // Restart the peak at a band's first bin or on a change of band
    assign w_sq   = r_b3.sq_re + r_b3.sq_im;
    assign w_base = (r_b3.first || (r_b3.band != r_cur_band)) ? 48'd0 : r_peak;
    assign w_new  = (w_sq > w_base) ? w_sq : w_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak     <= 48'd0;
            r_cur_band <= 4'd0;
        end else if (w_fire3) begin
            r_peak     <= w_new;
            r_cur_band <= r_b3.band;
        end
    end

    // Pass the closed band's peak on for level conversion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_rdy4) begin
            r_v4 <= w_fire3 && r_b3.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire3 && r_b3.last) begin
            r_b4.band <= r_b3.band;
            r_b4.peak <= w_new;
        end
    end

    assign o_valid = r_v4;
    assign o_beat  = r_b4;

endmodule

// File: design/spbm_level.sv
// Peak to bar level conversion, glyph lookup and output register.
module spbm_level import spbm_pkg::*; #(
    parameter int NUM_BANDS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_peak_beat i_beat,
    output logic       o_ready,
    output logic       o_valid,
    output t_band_beat o_beat,
    input  logic       i_ready
);

    localparam logic [3:0] LastBand = 4'(NUM_BANDS - 1);

    logic                  r_v5;
    t_band_beat            r_out;
    logic                  w_rdy5;
    logic [LevelCount-1:0] w_hits;
    logic [4:0]            w_lvl;

    assign w_rdy5  = !r_v5 || i_ready;
    assign o_ready = w_rdy5;

    // Count thresholds at or below the peak
    always_comb begin
        for (int k = 0; k < LevelCount; k++) begin
            w_hits[k] = (i_beat.peak >= LEVEL_THRESH[k]);
        end
    end

    assign w_lvl = 5'($countones(w_hits));

    // Hold the result beat until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_rdy5) begin
            r_v5 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && i_valid) begin
            r_out.band_number <= i_beat.band;
            r_out.bar_level   <= w_lvl;
            r_out.upper_glyph <= glyph_upper(w_lvl);
            r_out.lower_glyph <= glyph_lower(w_lvl);
            r_out.frame_done  <= (i_beat.band == LastBand);
        end
    end

    assign o_valid = r_v5;
    assign o_beat  = r_out;

endmodule

// File: design/spectrum_band_peak_meter.sv
// Spectrum band peak meter: log-band peak levels and bar glyphs from FFT bins.
//
// Bins stream in on i_bin and one beat can be taken every cycle while the
// pipeline is not held. Bins of index 0 or at TOP_BIN and above are taken and
// dropped. The squared magnitude of each bin is compared against the running
// maximum of its band; on the last bin of a band one beat leaves on o_band with
// the band number, the bar level (floor of 2.5 times the natural log of the peak
// magnitude, clamped 0..16), the two glyphs for that level, and frame_done on
// the last band. A report passes the input register, the band lookup register,
// the squared parts register and the peak register, and the level compare then
// loads the output register. The sustained rate of one bin per cycle, while no
// stage is held, is set by the peak update loop, a 48-bit add and compare that
// feeds the running peak register. Stages hold independently, so bins that close
// no band keep flowing past a report waiting at the output; the input stalls
// once a band-closing bin reaches the peak stage behind it.
module spectrum_band_peak_meter import spbm_pkg::*; #(
    parameter int NUM_BANDS = 16,
    parameter int TOP_BIN = 2205
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spbm_stream_if.sink   i_bin,
    spbm_stream_if.source o_band
);

`include "spectrum_band_peak_meter_assert.svh"

    logic       w_sq_valid;
    logic       w_sq_ready;
    t_sq_beat   w_sq_beat;
    logic       w_pk_valid;
    logic       w_pk_ready;
    t_peak_beat w_pk_beat;
    logic       w_in_ready;
    logic       w_out_valid;
    t_band_beat w_out_beat;
    logic       w_glyph_ok;
    logic       w_done_ok;
    logic       w_stalled;

    spbm_front #(
        .NUM_BANDS (NUM_BANDS),
        .TOP_BIN   (TOP_BIN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_bin.valid),
        .i_beat  (i_bin.payload),
        .o_ready (w_in_ready),
        .o_valid (w_sq_valid),
        .o_beat  (w_sq_beat),
        .i_ready (w_sq_ready)
    );

    spbm_peak u_peak (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .i_beat  (w_sq_beat),
        .o_ready (w_sq_ready),
        .o_valid (w_pk_valid),
        .o_beat  (w_pk_beat),
        .i_ready (w_pk_ready)
    );

    spbm_level #(
        .NUM_BANDS (NUM_BANDS)
    ) u_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pk_valid),
        .i_beat  (w_pk_beat),
        .o_ready (w_pk_ready),
        .o_valid (w_out_valid),
        .o_beat  (w_out_beat),
        .i_ready (o_band.ready)
    );

    assign i_bin.ready    = w_in_ready;
    assign o_band.valid   = w_out_valid;
    assign o_band.payload = w_out_beat;

    // Terms checked on the report beat
    assign w_glyph_ok = (w_out_beat.upper_glyph == GlyphBlank) ==
                        (w_out_beat.bar_level < 5'd9);
    assign w_done_ok  = w_out_beat.frame_done ==
                        (w_out_beat.band_number == 4'(NUM_BANDS - 1));
    assign w_stalled  = w_out_valid && !o_band.ready;

    // An empty output stage must let every stage behind it move
    `SPBM_ASSERT_NOW(a_ready_when_drained, !w_out_valid, w_in_ready, "stall with empty output")
    // Blank upper glyph exactly for the lower half of the scale
    `SPBM_ASSERT_NOW(a_upper_glyph_split, w_out_valid, w_glyph_ok, "upper glyph disagrees")
    // Frame end flag marks the last band only
    `SPBM_ASSERT_NOW(a_frame_done_band, w_out_valid, w_done_ok, "frame_done on wrong band")
    // A stalled report holds its beat
    `SPBM_ASSERT_NEXT(a_report_held, w_stalled, w_out_valid && $stable(w_out_beat), "report moved")

endmodule
